### src/polyphonic_voice_allocator_unit_defines.svh
// assertion macros for the checker file of the voice allocator
// no dependencies; take in with a plain include
`ifndef POLYPHONIC_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define PVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define PVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pva_pkg.sv
// types and constants of the polyphonic voice allocator
// no dependencies; used by the sequencer, the top level and the testbench
package pva_pkg;

    // largest legal note number and velocity
    localparam logic [7:0] NOTE_MAX   = 8'd127;
    // note value of a freed slot
    localparam logic [7:0] EMPTY_NOTE = 8'hFF;

    // event kinds
    typedef enum logic [1:0] {
        FUNC_NOTE_ON    = 2'd0,
        FUNC_NOTE_OFF   = 2'd1,
        FUNC_VOICE_DONE = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } t_state;

    // one slot of the voice table as held in memory
    typedef struct packed {
        logic [7:0] note;
        logic [6:0] level;
        logic       releasing;
    } t_entry;

    // one result transaction
    typedef struct packed {
        logic       status;
        logic [2:0] slot;
        logic       found;
        logic       allocated;
        logic       dropped;
        logic [3:0] active_count;
    } t_result;

endpackage

### src/pva_if.sv
// channel interfaces of the voice allocator: event in, result out
// depends on nothing; valid/ready handshake with source and sink modports
interface pva_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] note;
    logic [7:0] velocity;
    logic [2:0] voice_index;

    modport source (output valid, func, note, velocity, voice_index, input ready);
    modport sink   (input valid, func, note, velocity, voice_index, output ready);
endinterface

interface pva_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [2:0] slot;
    logic       found;
    logic       allocated;
    logic       dropped;
    logic [3:0] active_count;

    modport source (output valid, status, slot, found, allocated, dropped, active_count,
                    input ready);
    modport sink   (input valid, status, slot, found, allocated, dropped, active_count,
                    output ready);
endinterface

### src/polyphonic_voice_allocator_unit.sv
// sequence: an invalid event goes from idle straight to the result state; a search
// visits each active slot with a read state and then a compare state, since the
// table memory has a registered read.
// throughput: one event at a time, next event taken the cycle after its result
// moves to the output register.
// reset: synchronous, active low; clears voice count, sequencer, output valid.
module polyphonic_voice_allocator_unit #(
    parameter int VOICES = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pva_in_if.sink  i_evt,
    pva_out_if.source o_res
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    pva_pkg::t_entry  w_wr_data;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    pva_pkg::t_entry  w_rd_data;
    logic             w_res_valid;
    logic             w_res_ready;
    pva_pkg::t_result w_res;
    logic             r_out_valid;
    pva_pkg::t_result r_out;

    // voice table
    pva_ram #(
        .WIDTH ($bits(pva_pkg::t_entry)),
        .DEPTH (VOICES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // event sequencer
    pva_seq #(
        .VOICES (VOICES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (i_evt),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    // output register, refilled in the cycle it is taken
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.slot         = r_out.slot;
    assign o_res.found        = r_out.found;
    assign o_res.allocated    = r_out.allocated;
    assign o_res.dropped      = r_out.dropped;
    assign o_res.active_count = r_out.active_count;

endmodule

### src/pva_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/pva_seq.sv
// event sequencer: search, append, retrigger, release marking and shift-down of the table
// depends on pva_pkg, pva_if and a pva_ram instance driven by the top level
module pva_seq #(
    parameter int VOICES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pva_in_if.sink                 i_evt,
    // result towards the output register
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output pva_pkg::t_result       o_res,
    // table memory
    output logic                   o_wr_en,
    output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] o_wr_addr,
    output pva_pkg::t_entry        o_wr_data,
    output logic                   o_rd_en,
    output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] o_rd_addr,
    input  pva_pkg::t_entry        i_rd_data
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int XW = (CW > 3) ? CW : 3;
    localparam logic [CW-1:0] VOICES_C = CW'(VOICES);

    pva_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx,   n_idx;
    logic [1:0]       r_func,  n_func;
    logic [7:0]       r_note,  n_note;
    logic [7:0]       r_vel,   n_vel;
    pva_pkg::t_result r_res,   n_res;
    logic [CW:0]      w_idx_inc;

    assign w_idx_inc = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pva_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // event fields and result under construction
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_func <= n_func;
        r_note <= n_note;
        r_vel  <= n_vel;
        r_res  <= n_res;
    end

    // next state, memory accesses and result fields
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_func      = r_func;
        n_note      = r_note;
        n_vel       = r_vel;
        n_res       = r_res;
        i_evt.ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx[IW-1:0];
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx[IW-1:0];

        unique case (r_state)
            pva_pkg::ST_IDLE: begin
                i_evt.ready = 1'b1;
                if (i_evt.valid) begin
                    n_func                = i_evt.func;
                    n_note                = i_evt.note;
                    n_vel                 = i_evt.velocity;
                    n_idx                 = '0;
                    n_res                 = '0;
                    n_res.active_count    = 4'(r_count);
                    unique case (i_evt.func)
                        pva_pkg::FUNC_NOTE_ON: begin
                            if (i_evt.note > pva_pkg::NOTE_MAX ||
                                i_evt.velocity > pva_pkg::NOTE_MAX) begin
                                n_res.status = 1'b1;
                                n_state      = pva_pkg::ST_RESP;
                            end else begin
                                n_state = pva_pkg::ST_SRCH_RD;
                            end
                        end
                        pva_pkg::FUNC_NOTE_OFF: begin
                            if (i_evt.note > pva_pkg::NOTE_MAX) begin
                                n_res.status = 1'b1;
                                n_state      = pva_pkg::ST_RESP;
                            end else begin
                                n_state = pva_pkg::ST_SRCH_RD;
                            end
                        end
                        pva_pkg::FUNC_VOICE_DONE: begin
                            n_res.slot = i_evt.voice_index;
                            if (XW'(i_evt.voice_index) >= XW'(r_count)) begin
                                n_res.status = 1'b1;
                                n_state      = pva_pkg::ST_RESP;
                            end else begin
                                n_idx   = CW'(i_evt.voice_index);
                                n_state = pva_pkg::ST_SHIFT_RD;
                            end
                        end
                        default: begin
                            n_res.status = 1'b1;
                            n_state      = pva_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            // issue a read of the next active slot, or finish the search and append a missed note-on
            pva_pkg::ST_SRCH_RD: begin
                if (r_idx < r_count) begin
                    o_rd_en = 1'b1;
                    n_state = pva_pkg::ST_SRCH_CMP;
                end else begin
                    n_state = pva_pkg::ST_RESP;
                    if (r_func == pva_pkg::FUNC_NOTE_ON) begin
                        if (r_count < VOICES_C) begin
                            o_wr_en             = 1'b1;
                            o_wr_addr           = r_count[IW-1:0];
                            o_wr_data.note      = r_note;
                            o_wr_data.level     = r_vel[6:0];
                            o_wr_data.releasing = 1'b0;
                            n_count             = w_idx_inc[CW-1:0];
                            n_res.slot          = 3'(r_count);
                            n_res.allocated     = 1'b1;
                            n_res.active_count  = 4'(w_idx_inc);
                        end else begin
                            n_res.dropped = 1'b1;
                        end
                    end
                end
            end

            // compare the slot read back, retrigger or mark releasing on a match
            pva_pkg::ST_SRCH_CMP: begin
                if (i_rd_data.note == r_note) begin
                    n_res.found = 1'b1;
                    n_res.slot  = 3'(r_idx);
                    o_wr_en     = 1'b1;
                    if (r_func == pva_pkg::FUNC_NOTE_ON) begin
                        o_wr_data.note      = r_note;
                        o_wr_data.level     = r_vel[6:0];
                        o_wr_data.releasing = 1'b0;
                    end else begin
                        o_wr_data           = i_rd_data;
                        o_wr_data.releasing = 1'b1;
                    end
                    n_state = pva_pkg::ST_RESP;
                end else begin
                    n_idx   = w_idx_inc[CW-1:0];
                    n_state = pva_pkg::ST_SRCH_RD;
                end
            end

            // read the slot above, or clear the freed top slot
            pva_pkg::ST_SHIFT_RD: begin
                if (w_idx_inc < {1'b0, r_count}) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_idx_inc[IW-1:0];
                    n_state   = pva_pkg::ST_SHIFT_WR;
                end else begin
                    o_wr_en             = 1'b1;
                    o_wr_data.note      = pva_pkg::EMPTY_NOTE;
                    o_wr_data.level     = '0;
                    o_wr_data.releasing = 1'b0;
                    n_count             = r_count - CW'(1);
                    n_res.active_count  = 4'(r_count - CW'(1));
                    n_state             = pva_pkg::ST_RESP;
                end
            end

            // move the slot above down by one
            pva_pkg::ST_SHIFT_WR: begin
                o_wr_en   = 1'b1;
                o_wr_data = i_rd_data;
                n_idx     = w_idx_inc[CW-1:0];
                n_state   = pva_pkg::ST_SHIFT_RD;
            end

            // hand the result to the output register
            pva_pkg::ST_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = pva_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pva_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

### src/pva_chk.sv
// port-level checker for the voice allocator result channel, with its bind
// depends on polyphonic_voice_allocator_unit_defines.svh and the top level
`include "polyphonic_voice_allocator_unit_defines.svh"

module pva_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_status,
    input logic [2:0] i_slot,
    input logic       i_found,
    input logic       i_allocated,
    input logic       i_dropped,
    input logic [3:0] i_active_count
);

    logic [3:0] w_prev_count;

    // voice count before an append
    assign w_prev_count = i_active_count - 4'd1;

    // a stalled result transaction keeps its payload
    `PVA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_slot) && $stable(i_found) && $stable(i_allocated) && $stable(i_dropped) && $stable(i_active_count), "result changed while stalled")

    // reset empties the output register
    `PVA_ASSERT_ALWAYS(a_out_reset, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // an event has at most one outcome
    `PVA_ASSERT(a_one_outcome, i_clk, i_rst_n, i_out_valid |-> $countones({i_status, i_found, i_allocated, i_dropped}) <= 1, "more than one outcome flag set")

    // an append takes the slot just past the previous count
    `PVA_ASSERT(a_append_slot, i_clk, i_rst_n, i_out_valid && i_allocated |-> i_slot == w_prev_count[2:0], "appended slot does not follow the count")

endmodule

bind polyphonic_voice_allocator_unit pva_chk u_pva_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_slot         (o_res.slot),
    .i_found        (o_res.found),
    .i_allocated    (o_res.allocated),
    .i_dropped      (o_res.dropped),
    .i_active_count (o_res.active_count)
);

### verif/polyphonic_voice_allocator_unit_tb.sv
`timescale 1ns / 1ps
// testbench of the voice allocator: random and directed note events, with each result
// checked field by field against a voice table kept alongside the block
// depends on pva_pkg, the pva_in_if / pva_out_if interfaces and the allocator rtl
module polyphonic_voice_allocator_unit_tb;

    localparam int NVOICE = 8;
    // event kind outside the enum, rejected by the block
    localparam logic [1:0] FUNC_BAD = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 2 * NVOICE + 8;
    localparam int RANDOM_PER_PHASE = 530;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [2:0] voice_index;
    } t_evt;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pva_in_if  evt_if ();
    pva_out_if res_if ();

    polyphonic_voice_allocator_unit #(
        .VOICES (NVOICE)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if)
    );

    // shadow voice table
    logic [7:0]  tbl_note    [NVOICE];
    logic [6:0]  tbl_level   [NVOICE];
    logic        tbl_rel     [NVOICE];
    int unsigned tbl_count;

    t_evt             event_fifo[$];
    pva_pkg::t_result pending_results[$];
    t_evt             drive_evt;
    pva_pkg::t_result got_res;
    pva_pkg::t_result want_res;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned err_cnt;

    // clock
    always #1 i_clk = ~i_clk;

    // applies one event to the shadow table and returns the result it should give
    function automatic pva_pkg::t_result voice_table_step(t_evt e);
        pva_pkg::t_result r;
        bit hit;
        int unsigned i;
        r = '0;
        hit = 1'b0;
        unique case (e.func)
            pva_pkg::FUNC_NOTE_ON: begin
                if (e.note > pva_pkg::NOTE_MAX || e.velocity > pva_pkg::NOTE_MAX) begin
                    r.status = 1'b1;
                end else begin
                    for (i = 0; i < tbl_count && !hit; i++) begin
                        if (tbl_note[i] == e.note) begin
                            hit = 1'b1;
                            r.slot = i[2:0];
                        end
                    end
                    r.found = hit;
                    if (!hit) begin
                        if (tbl_count < NVOICE) begin
                            r.slot = tbl_count[2:0];
                            r.allocated = 1'b1;
                            tbl_count++;
                        end else begin
                            r.dropped = 1'b1;
                        end
                    end
                    if (hit || r.allocated) begin
                        tbl_note[r.slot]  = e.note;
                        tbl_level[r.slot] = e.velocity[6:0];
                        tbl_rel[r.slot]   = 1'b0;
                    end
                end
            end
            pva_pkg::FUNC_NOTE_OFF: begin
                if (e.note > pva_pkg::NOTE_MAX) begin
                    r.status = 1'b1;
                end else begin
                    for (i = 0; i < tbl_count && !hit; i++) begin
                        if (tbl_note[i] == e.note) begin
                            hit = 1'b1;
                            r.slot = i[2:0];
                            tbl_rel[i] = 1'b1;
                        end
                    end
                    r.found = hit;
                end
            end
            pva_pkg::FUNC_VOICE_DONE: begin
                r.slot = e.voice_index;
                if (e.voice_index >= tbl_count) begin
                    r.status = 1'b1;
                end else begin
                    tbl_count--;
                    for (i = e.voice_index; i < tbl_count; i++) begin
                        tbl_note[i]  = tbl_note[i + 1];
                        tbl_level[i] = tbl_level[i + 1];
                        tbl_rel[i]   = tbl_rel[i + 1];
                    end
                    tbl_note[tbl_count]  = pva_pkg::EMPTY_NOTE;
                    tbl_level[tbl_count] = '0;
                    tbl_rel[tbl_count]   = 1'b0;
                end
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.active_count = tbl_count[3:0];
        return r;
    endfunction

    function automatic void cmp_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // an active note with the given percent chance, so that retriggers and note-offs hit
    function automatic logic [7:0] pick_note(int unsigned active_pct);
        if (tbl_count > 0 && $urandom_range(0, 99) < active_pct)
            return tbl_note[$urandom_range(0, tbl_count - 1)];
        return 8'($urandom_range(0, 127));
    endfunction

    // well-formed events with random content, some noise
    function automatic t_evt random_event();
        t_evt e;
        int unsigned roll;
        e.func        = 2'($urandom_range(0, 3));
        e.note        = 8'($urandom_range(0, 255));
        e.velocity    = 8'($urandom_range(0, 255));
        e.voice_index = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 12)
            return e;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            e.func     = pva_pkg::FUNC_NOTE_ON;
            e.note     = pick_note(40);
            e.velocity = 8'($urandom_range(0, 127));
        end else if (roll < 70) begin
            e.func = pva_pkg::FUNC_NOTE_OFF;
            e.note = pick_note(70);
        end else begin
            e.func = pva_pkg::FUNC_VOICE_DONE;
            e.voice_index = (tbl_count > 0) ? 3'($urandom_range(0, tbl_count - 1)) : 3'd0;
        end
        return e;
    endfunction

    task automatic queue_event(logic [1:0] func, logic [7:0] note, logic [7:0] vel,
                               logic [2:0] idx);
        event_fifo.push_back(t_evt'{func: func, note: note, velocity: vel,
                                    voice_index: idx});
    endtask

    // keep the driver fed a couple of transactions ahead of the table state
    task automatic feed_random(int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++) begin
            while (event_fifo.size() >= 2)
                @(negedge i_clk);
            event_fifo.push_back(random_event());
        end
    endtask

    // sender pauses until every expected result is back and the block has settled
    task automatic wait_drained();
        while (event_fifo.size() != 0 || evt_if.valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // event driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else if (!evt_if.valid || evt_if.ready) begin
            if (event_fifo.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                drive_evt = event_fifo.pop_front();
                evt_if.valid       <= 1'b1;
                evt_if.func        <= drive_evt.func;
                evt_if.note        <= drive_evt.note;
                evt_if.velocity    <= drive_evt.velocity;
                evt_if.voice_index <= drive_evt.voice_index;
            end else begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            res_if.ready <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // monitor: check results, predict on each accepted event
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got_res = pva_pkg::t_result'{status: res_if.status, slot: res_if.slot,
                            found: res_if.found, allocated: res_if.allocated,
                            dropped: res_if.dropped, active_count: res_if.active_count};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time, got_res);
                    err_cnt++;
                end else begin
                    want_res = pending_results.pop_front();
                    cmp_field("status", want_res.status, got_res.status);
                    cmp_field("slot", want_res.slot, got_res.slot);
                    cmp_field("found", want_res.found, got_res.found);
                    cmp_field("allocated", want_res.allocated, got_res.allocated);
                    cmp_field("dropped", want_res.dropped, got_res.dropped);
                    cmp_field("active_count", want_res.active_count, got_res.active_count);
                end
            end
            if (evt_if.valid && evt_if.ready)
                pending_results.push_back(voice_table_step(t_evt'{func: evt_if.func,
                    note: evt_if.note, velocity: evt_if.velocity,
                    voice_index: evt_if.voice_index}));
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        int unsigned ph;
        int unsigned idx;
        i_rst_n            = 1'b0;
        evt_if.valid       = 1'b0;
        evt_if.func        = '0;
        evt_if.note        = '0;
        evt_if.velocity    = '0;
        evt_if.voice_index = '0;
        res_if.ready       = 1'b0;
        tx_idle_pct  = 23;
        rx_idle_pct  = 67;
        hold_req     = 0;
        hold_seen    = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        err_cnt      = 0;
        tbl_count    = 0;
        for (idx = 0; idx < NVOICE; idx++) begin
            tbl_note[idx]  = pva_pkg::EMPTY_NOTE;
            tbl_level[idx] = '0;
            tbl_rel[idx]   = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, invalid arguments, fill, drop, removal
        queue_event(pva_pkg::FUNC_VOICE_DONE, 8'd0, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_VOICE_DONE, 8'd0, 8'd0, 3'd7);
        queue_event(pva_pkg::FUNC_NOTE_OFF, 8'd5, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd200, 8'd10, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd10, 8'd128, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd255, 8'd255, 3'd7);
        queue_event(FUNC_BAD, 8'd0, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd0, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd127, 8'd127, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_OFF, 8'd127, 8'd0, 3'd0);
        // retrigger of a releasing voice
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd127, 8'd64, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_OFF, 8'd128, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_OFF, 8'd60, 8'd0, 3'd0);
        for (idx = 0; idx < 6; idx++)
            queue_event(pva_pkg::FUNC_NOTE_ON, 8'(60 + idx), 8'(20 * idx), 3'd0);
        // full table: new note dropped, known note retriggered
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd66, 8'd1, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd0, 8'd99, 3'd0);
        queue_event(pva_pkg::FUNC_VOICE_DONE, 8'd0, 8'd0, 3'd7);
        queue_event(pva_pkg::FUNC_VOICE_DONE, 8'd0, 8'd0, 3'd7);
        queue_event(pva_pkg::FUNC_VOICE_DONE, 8'd0, 8'd0, 3'd0);
        queue_event(pva_pkg::FUNC_NOTE_ON, 8'd70, 8'd33, 3'd0);
        wait_drained();

        // random phases with swapped idling, then none
        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 67 : 0;
            rx_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 23 : 0;
            if (ph == 0) begin
                feed_random(RANDOM_PER_PHASE / 2);
                hold_req++;
                feed_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
            end else begin
                feed_random(RANDOM_PER_PHASE);
            end
            wait_drained();
        end

        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### polyphonic_voice_allocator_unit.f
+incdir+src
src/pva_pkg.sv
src/pva_if.sv
src/pva_ram.sv
src/pva_seq.sv
src/polyphonic_voice_allocator_unit.sv
src/pva_chk.sv
verif/polyphonic_voice_allocator_unit_tb.sv
